### sv/olsr_pkg.sv
package olsr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned TIME_W  = 20;

  localparam logic [7:0] MANT_MASK = 8'hF0;
  localparam logic [7:0] EXPO_MASK = 8'h0F;
  localparam logic [4:0] MANT_BIAS = 5'd16;

  typedef enum logic [3:0] {
    KIND_PKT_HDR  = 4'd0,
    KIND_MSG_HDR  = 4'd1,
    KIND_ORIGIN   = 4'd2,
    KIND_TTL_SEQ  = 4'd3,
    KIND_ANSN     = 4'd4,
    KIND_TC_NBR   = 4'd5,
    KIND_HELLO    = 4'd6,
    KIND_LINK_HDR = 4'd7,
    KIND_LINK_NBR = 4'd8,
    KIND_MID      = 4'd9,
    KIND_HNA_NET  = 4'd10,
    KIND_HNA_MASK = 4'd11,
    KIND_SKIP     = 4'd12,
    KIND_EXCESS   = 4'd13
  } kind_t;

  typedef enum logic [7:0] {
    MSG_HELLO = 8'd1,
    MSG_TC    = 8'd2,
    MSG_MID   = 8'd3,
    MSG_HNA   = 8'd4
  } msg_type_t;

  typedef enum logic [2:0] {
    TCLASS_HELLO   = 3'd0,
    TCLASS_TC      = 3'd1,
    TCLASS_MID     = 3'd2,
    TCLASS_HNA     = 3'd3,
    TCLASS_INVALID = 3'd4
  } type_class_t;

  typedef enum logic [2:0] {
    WILL_NEVER   = 3'd0,
    WILL_LOW     = 3'd1,
    WILL_DEFAULT = 3'd2,
    WILL_HIGH    = 3'd3,
    WILL_ALWAYS  = 3'd4,
    WILL_INVALID = 3'd5
  } will_class_t;

  typedef enum logic [2:0] {
    LINK_UNSPEC  = 3'd0,
    LINK_ASYM    = 3'd1,
    LINK_SYM     = 3'd2,
    LINK_LOST    = 3'd3,
    LINK_MPR     = 3'd4,
    LINK_PENDING = 3'd5,
    LINK_INVALID = 3'd6
  } link_class_t;

  // raw willingness and link-type codes as they appear on the wire
  localparam logic [7:0] WCODE_NEVER   = 8'd0;
  localparam logic [7:0] WCODE_LOW     = 8'd1;
  localparam logic [7:0] WCODE_DEFAULT = 8'd3;
  localparam logic [7:0] WCODE_HIGH    = 8'd6;
  localparam logic [7:0] WCODE_ALWAYS  = 8'd7;

  localparam logic [7:0] LCODE_UNSPEC  = 8'd0;
  localparam logic [7:0] LCODE_ASYM    = 8'd1;
  localparam logic [7:0] LCODE_LOST    = 8'd3;
  localparam logic [7:0] LCODE_PENDING = 8'd5;
  localparam logic [7:0] LCODE_SYM     = 8'd6;
  localparam logic [7:0] LCODE_MPR     = 8'd10;

  // per-word parse result handed from the parser to the field decoder
  typedef struct packed {
    kind_t      kind;
    logic [7:0] mtype;
    logic [1:0] part;
    logic       last;
  } parse_res_t;

  // byte size to following 32-bit words, short sizes count as none
  function automatic logic [COUNT_W-1:0] words_after(input logic [15:0] bytes);
    logic [15:0] rest;
    rest = bytes - 16'd4;
    return (bytes >= 16'd4) ? rest[COUNT_W+1:2] : '0;
  endfunction

  // (16 + mantissa) << exponent, in 1/256 s
  function automatic logic [TIME_W-1:0] time_decode(input logic [7:0] code);
    logic [7:0]        mant;
    logic [7:0]        expo;
    logic [TIME_W-1:0] base;
    mant = (code & MANT_MASK) >> 4;
    expo = code & EXPO_MASK;
    base = {{(TIME_W-5){1'b0}}, MANT_BIAS + mant[4:0]};
    return base << expo[3:0];
  endfunction

endpackage

### sv/olsr_if.sv
interface olsr_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic        first_word;

  modport source (output valid, packet_word, first_word, input ready);
  modport sink   (input valid, packet_word, first_word, output ready);
endinterface

interface olsr_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_kind;
  logic [7:0]  msg_type;
  logic [2:0]  type_class;
  logic [19:0] time_value;
  logic [2:0]  willingness_class;
  logic [2:0]  link_class;
  logic [1:0]  address_part;
  logic [31:0] word_echo;
  logic        last_of_packet;

  modport source (output valid, word_kind, msg_type, type_class, time_value,
                  willingness_class, link_class, address_part, word_echo,
                  last_of_packet, input ready);
  modport sink   (input valid, word_kind, msg_type, type_class, time_value,
                  willingness_class, link_class, address_part, word_echo,
                  last_of_packet, output ready);
endinterface

### sv/olsr_parse_fsm.sv
module olsr_parse_fsm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             ipv6,
  input  logic [olsr_pkg::WORD_W-1:0]      word,
  input  logic                             first,
  output olsr_pkg::parse_res_t             res
);
  import olsr_pkg::*;

  typedef enum logic [3:0] {
    PH_PKT, PH_MSG, PH_ORIG, PH_TTL, PH_ANSN, PH_TCNBR, PH_HELLO,
    PH_LINKHDR, PH_LINKNBR, PH_MID, PH_HNA, PH_SKIP
  } phase_t;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] pkt_left, pkt_left_next;
  logic [COUNT_W-1:0] msg_left, msg_left_next;
  logic [COUNT_W-1:0] link_left, link_left_next;
  logic [7:0]         cur_type, cur_type_next;
  logic [1:0]         addr_idx, addr_idx_next;
  logic               mask_half, mask_half_next;

  logic [COUNT_W-1:0] msg_dec;
  logic [COUNT_W-1:0] link_dec;
  logic [1:0]         apart;
  logic               adone;
  logic [1:0]         aidx_adv;

  // address word stepping: one word in ipv4, four in ipv6
  always_comb begin
    if (!ipv6) begin
      apart    = '0;
      adone    = 1'b1;
      aidx_adv = '0;
    end else begin
      apart    = addr_idx;
      adone    = (addr_idx == 2'd3);
      aidx_adv = addr_idx + 2'd1;
    end
  end

  assign msg_dec  = (msg_left != '0) ? msg_left - 1'b1 : '0;
  assign link_dec = (link_left != '0) ? link_left - 1'b1 : '0;

  always_comb begin
    phase_next     = phase;
    pkt_left_next  = pkt_left;
    msg_left_next  = msg_left;
    link_left_next = link_left;
    cur_type_next  = cur_type;
    addr_idx_next  = addr_idx;
    mask_half_next = mask_half;
    res.kind       = KIND_EXCESS;
    res.part       = '0;
    res.last       = 1'b0;

    if (first) begin
      pkt_left_next  = words_after(word[31:16]);
      msg_left_next  = '0;
      link_left_next = '0;
      addr_idx_next  = '0;
      mask_half_next = 1'b0;
      phase_next     = (pkt_left_next != '0) ? PH_MSG : PH_PKT;
      res.kind       = KIND_PKT_HDR;
      res.last       = (pkt_left_next == '0);
    end else if (phase == PH_PKT || pkt_left == '0) begin
      phase_next = PH_PKT;
      res.kind   = KIND_EXCESS;
    end else begin
      pkt_left_next = pkt_left - 1'b1;
      if (phase == PH_MSG) begin
        res.kind       = KIND_MSG_HDR;
        cur_type_next  = word[31:24];
        msg_left_next  = words_after(word[15:0]);
        addr_idx_next  = '0;
        mask_half_next = 1'b0;
        link_left_next = '0;
        phase_next     = (msg_left_next != '0) ? PH_ORIG : PH_MSG;
      end else begin
        msg_left_next = msg_dec;
        unique case (phase)
          PH_ORIG: begin
            res.kind      = KIND_ORIGIN;
            res.part      = apart;
            addr_idx_next = aidx_adv;
            if (adone) phase_next = PH_TTL;
          end
          PH_TTL: begin
            res.kind       = KIND_TTL_SEQ;
            addr_idx_next  = '0;
            mask_half_next = 1'b0;
            case (cur_type)
              MSG_TC:    phase_next = PH_ANSN;
              MSG_HELLO: phase_next = PH_HELLO;
              MSG_MID:   phase_next = PH_MID;
              MSG_HNA:   phase_next = PH_HNA;
              default:   phase_next = PH_SKIP;
            endcase
          end
          PH_ANSN: begin
            res.kind   = KIND_ANSN;
            phase_next = PH_TCNBR;
          end
          PH_TCNBR: begin
            res.kind      = KIND_TC_NBR;
            res.part      = apart;
            addr_idx_next = aidx_adv;
          end
          PH_HELLO: begin
            res.kind   = KIND_HELLO;
            phase_next = PH_LINKHDR;
          end
          PH_LINKHDR: begin
            res.kind       = KIND_LINK_HDR;
            link_left_next = words_after(word[15:0]);
            addr_idx_next  = '0;
            phase_next     = (link_left_next != '0) ? PH_LINKNBR : PH_LINKHDR;
          end
          PH_LINKNBR: begin
            res.kind       = KIND_LINK_NBR;
            res.part       = apart;
            addr_idx_next  = aidx_adv;
            link_left_next = link_dec;
            if (link_dec == '0) begin
              addr_idx_next = '0;
              phase_next    = PH_LINKHDR;
            end
          end
          PH_MID: begin
            res.kind      = KIND_MID;
            res.part      = apart;
            addr_idx_next = aidx_adv;
          end
          PH_HNA: begin
            res.kind      = mask_half ? KIND_HNA_MASK : KIND_HNA_NET;
            res.part      = apart;
            addr_idx_next = aidx_adv;
            if (adone) mask_half_next = ~mask_half;
          end
          default: begin
            res.kind   = KIND_SKIP;
            phase_next = PH_SKIP;
          end
        endcase
        // message used up, next word is a message header
        if (msg_dec == '0) begin
          phase_next     = PH_MSG;
          addr_idx_next  = '0;
          mask_half_next = 1'b0;
          link_left_next = '0;
        end
      end
      // packet used up, abandon whatever is open
      if (pkt_left_next == '0) begin
        phase_next     = PH_PKT;
        msg_left_next  = '0;
        link_left_next = '0;
        addr_idx_next  = '0;
        mask_half_next = 1'b0;
        res.last       = 1'b1;
      end
    end

    res.mtype = (res.kind == KIND_PKT_HDR || res.kind == KIND_EXCESS) ? 8'd0 : cur_type_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PKT;
      pkt_left  <= '0;
      msg_left  <= '0;
      link_left <= '0;
      cur_type  <= '0;
      addr_idx  <= '0;
      mask_half <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      pkt_left  <= pkt_left_next;
      msg_left  <= msg_left_next;
      link_left <= link_left_next;
      cur_type  <= cur_type_next;
      addr_idx  <= addr_idx_next;
      mask_half <= mask_half_next;
    end
  end

endmodule

### sv/olsr_field_dec.sv
module olsr_field_dec (
  input  olsr_pkg::kind_t                  kind,
  input  logic [7:0]                       mtype,
  input  logic [olsr_pkg::WORD_W-1:0]      word,
  output olsr_pkg::type_class_t            tclass,
  output logic [olsr_pkg::TIME_W-1:0]      tval,
  output olsr_pkg::will_class_t            will,
  output olsr_pkg::link_class_t            link
);
  import olsr_pkg::*;

  always_comb begin
    if (kind == KIND_PKT_HDR || kind == KIND_EXCESS) begin
      tclass = TCLASS_INVALID;
    end else begin
      case (mtype)
        MSG_HELLO: tclass = TCLASS_HELLO;
        MSG_TC:    tclass = TCLASS_TC;
        MSG_MID:   tclass = TCLASS_MID;
        MSG_HNA:   tclass = TCLASS_HNA;
        default:   tclass = TCLASS_INVALID;
      endcase
    end
  end

  // validity time in byte 1 of a message header, hello interval in byte 2
  always_comb begin
    case (kind)
      KIND_MSG_HDR: tval = time_decode(word[23:16]);
      KIND_HELLO:   tval = time_decode(word[15:8]);
      default:      tval = '0;
    endcase
  end

  always_comb begin
    will = WILL_INVALID;
    if (kind == KIND_HELLO) begin
      unique case (word[7:0])
        WCODE_NEVER:   will = WILL_NEVER;
        WCODE_LOW:     will = WILL_LOW;
        WCODE_DEFAULT: will = WILL_DEFAULT;
        WCODE_HIGH:    will = WILL_HIGH;
        WCODE_ALWAYS:  will = WILL_ALWAYS;
        default:       will = WILL_INVALID;
      endcase
    end
  end

  always_comb begin
    link = LINK_INVALID;
    if (kind == KIND_LINK_HDR) begin
      unique case (word[31:24])
        LCODE_UNSPEC:  link = LINK_UNSPEC;
        LCODE_ASYM:    link = LINK_ASYM;
        LCODE_SYM:     link = LINK_SYM;
        LCODE_LOST:    link = LINK_LOST;
        LCODE_MPR:     link = LINK_MPR;
        LCODE_PENDING: link = LINK_PENDING;
        default:       link = LINK_INVALID;
      endcase
    end
  end

endmodule

### sv/olsr_packet_word_parser_unit.sv
// olsr packet word parser: takes an olsr payload one 32-bit word per beat
// (network byte order, first byte in bits 31..24) and returns exactly one
// result beat per word, tagging it by kind (packet header, message header,
// originator, ttl/hop/seq, ansn, tc neighbor, hello params, link header,
// link neighbor, mid interface, hna network/netmask, skipped, excess) and
// decoding message type class, validity/hello time in 1/256 s, willingness
// and link type. first_word forces a new packet at any point. cfg_wdata
// selects ipv4 (0, one word per address) or ipv6 (1, four words per address)
// and must be written only while no word is in flight; the block itself
// does not enforce this. throughput is one word per clock while results.ready
// holds; a word passes the input register, then the result register, with the
// counter update and byte decode in between. the result register and the input
// register form a two-deep pipe, so a new word is taken while a finished result
// still waits for ready. no memories, no clearing pass after reset.
module olsr_packet_word_parser_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  olsr_word_if.sink            words,
  olsr_result_if.source        results
);
  import olsr_pkg::*;

  // configuration
  logic ipv6;

  // input register
  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_first;

  // result register
  logic              res_valid;
  kind_t             res_kind;
  logic [7:0]        res_mtype;
  type_class_t       res_tclass;
  logic [TIME_W-1:0] res_tval;
  will_class_t       res_will;
  link_class_t       res_link;
  logic [1:0]        res_part;
  logic [WORD_W-1:0] res_word;
  logic              res_last;

  // decode of the word in the input register
  parse_res_t        pres;
  type_class_t       dec_tclass;
  logic [TIME_W-1:0] dec_tval;
  will_class_t       dec_will;
  link_class_t       dec_link;

  logic advance;

  // word moves to the result register when that register is free or drains
  assign advance     = in_valid && (!res_valid || results.ready);
  assign words.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ipv6 <= 1'b0;
    end else if (cfg_we) begin
      ipv6 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (words.ready) begin
      in_valid <= words.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      in_word  <= words.packet_word;
      in_first <= words.first_word;
    end
  end

  olsr_parse_fsm u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ipv6    (ipv6),
    .word    (in_word),
    .first   (in_first),
    .res     (pres)
  );

  olsr_field_dec u_dec (
    .kind   (pres.kind),
    .mtype  (pres.mtype),
    .word   (in_word),
    .tclass (dec_tclass),
    .tval   (dec_tval),
    .will   (dec_will),
    .link   (dec_link)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_kind   <= pres.kind;
      res_mtype  <= pres.mtype;
      res_tclass <= dec_tclass;
      res_tval   <= dec_tval;
      res_will   <= dec_will;
      res_link   <= dec_link;
      res_part   <= pres.part;
      res_word   <= in_word;
      res_last   <= pres.last;
    end
  end

  // result beat
  assign results.valid             = res_valid;
  assign results.word_kind         = res_kind;
  assign results.msg_type          = res_mtype;
  assign results.type_class        = res_tclass;
  assign results.time_value        = res_tval;
  assign results.willingness_class = res_will;
  assign results.link_class        = res_link;
  assign results.address_part      = res_part;
  assign results.word_echo         = res_word;
  assign results.last_of_packet    = res_last;

endmodule

### sv/olsr_checker.sv
module olsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [3:0]  word_kind,
  input logic [7:0]  msg_type,
  input logic [2:0]  type_class,
  input logic [19:0] time_value,
  input logic        last_of_packet,
  input logic [31:0] word_echo
);
  import olsr_pkg::*;

  // result beat stays and holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(word_echo) && $stable(word_kind))
    else $error("result beat dropped or changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // header and excess words belong to no message
  a_no_msg: assert property (@(posedge clk) disable iff (rst)
    res_valid && (word_kind == KIND_PKT_HDR || word_kind == KIND_EXCESS)
    |-> msg_type == 8'd0 && type_class == TCLASS_INVALID)
    else $error("message fields on a header or excess word");

  a_excess: assert property (@(posedge clk) disable iff (rst)
    res_valid && word_kind == KIND_EXCESS |-> !last_of_packet)
    else $error("excess word flagged as end of packet");

  a_time: assert property (@(posedge clk) disable iff (rst)
    res_valid && time_value != 20'd0
    |-> word_kind == KIND_MSG_HDR || word_kind == KIND_HELLO)
    else $error("time value on a word that carries none");

endmodule

bind olsr_packet_word_parser_unit olsr_checker u_olsr_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .word_kind      (results.word_kind),
  .msg_type       (results.msg_type),
  .type_class     (results.type_class),
  .time_value     (results.time_value),
  .last_of_packet (results.last_of_packet),
  .word_echo      (results.word_echo)
);

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olsr_pkg::*;

  // receiver hold-off used to fill the two-deep pipe and stall the input
  localparam int HOLD_CYCLES  = 64;
  // random words per phase, six phases plus the directed part give about 500 words
  localparam int PHASE_WORDS  = 72;
  localparam int PHASES       = 6;
  // extra cycles after the last result
  localparam int DRAIN_CYCLES = 12;

  // parser position, named after the part of the packet expected next
  typedef enum logic [3:0] {
    PH_PACKET,
    PH_MSG_HDR,
    PH_ORIGIN,
    PH_TTL,
    PH_ANSN,
    PH_TC_NBR,
    PH_HELLO,
    PH_LINK_HDR,
    PH_LINK_NBR,
    PH_MID,
    PH_HNA,
    PH_SKIP
  } parse_phase_t;

  // one decoded word as the block reports it
  typedef struct packed {
    kind_t        kind;
    logic [7:0]   mtype;
    type_class_t  tclass;
    logic [19:0]  tval;
    will_class_t  will;
    link_class_t  link;
    logic [1:0]   part;
    logic [31:0]  echo;
    logic         last;
  } word_result_t;

  typedef struct {
    logic [31:0] w;
    logic        f;
  } beat_t;

  // tracks the packet, message and link counters and holds the decoded
  // words that the block still owes
  class word_scoreboard;
    bit             ipv6;
    parse_phase_t   phase;
    logic [13:0]    pkt_left;
    logic [13:0]    msg_left;
    logic [13:0]    link_left;
    logic [7:0]     cur_type;
    logic [1:0]     addr_idx;
    logic           mask_half;
    word_result_t   owed[$];
    int             mismatches;
    int             checked;

    function new();
      ipv6       = 0;
      phase      = PH_PACKET;
      pkt_left   = '0;
      msg_left   = '0;
      link_left  = '0;
      cur_type   = '0;
      addr_idx   = '0;
      mask_half  = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // bytes announced by a size field to following words
    function logic [13:0] size_to_words(logic [15:0] bytes);
      logic [15:0] rest;
      if (bytes < 16'd4) return '0;
      rest = bytes - 16'd4;
      return rest[15:2];
    endfunction

    // 8-bit time code to 1/256 s
    function logic [19:0] code_to_time(logic [7:0] code);
      logic [19:0] base;
      base = 20'd16 + code[7:4];
      return base << code[3:0];
    endfunction

    function type_class_t class_of(logic [7:0] t);
      case (t)
        MSG_HELLO: return TCLASS_HELLO;
        MSG_TC:    return TCLASS_TC;
        MSG_MID:   return TCLASS_MID;
        MSG_HNA:   return TCLASS_HNA;
        default:   return TCLASS_INVALID;
      endcase
    endfunction

    function will_class_t willingness_of(logic [7:0] c);
      case (c)
        WCODE_NEVER:   return WILL_NEVER;
        WCODE_LOW:     return WILL_LOW;
        WCODE_DEFAULT: return WILL_DEFAULT;
        WCODE_HIGH:    return WILL_HIGH;
        WCODE_ALWAYS:  return WILL_ALWAYS;
        default:       return WILL_INVALID;
      endcase
    endfunction

    function link_class_t link_of(logic [7:0] c);
      case (c)
        LCODE_UNSPEC:  return LINK_UNSPEC;
        LCODE_ASYM:    return LINK_ASYM;
        LCODE_SYM:     return LINK_SYM;
        LCODE_LOST:    return LINK_LOST;
        LCODE_MPR:     return LINK_MPR;
        LCODE_PENDING: return LINK_PENDING;
        default:       return LINK_INVALID;
      endcase
    endfunction

    // word index within the current address, done on its last word
    function logic [1:0] addr_step(output bit done);
      logic [1:0] p;
      if (!ipv6) begin
        addr_idx = '0;
        done = 1;
        return '0;
      end
      p = addr_idx;
      done = (p == 2'd3);
      addr_idx = p + 2'd1;
      return p;
    endfunction

    // accepted input word: advance the counters and owe one decoded word
    function void note_word(logic [31:0] w, logic f);
      word_result_t r;
      bit           done;
      r.kind  = KIND_EXCESS;
      r.tval  = '0;
      r.will  = WILL_INVALID;
      r.link  = LINK_INVALID;
      r.part  = '0;
      r.echo  = w;
      r.last  = 0;
      if (f) begin
        // a header always restarts, whatever was in progress
        pkt_left  = size_to_words(w[31:16]);
        msg_left  = '0;
        link_left = '0;
        addr_idx  = '0;
        mask_half = 0;
        phase     = (pkt_left != 0) ? PH_MSG_HDR : PH_PACKET;
        r.kind    = KIND_PKT_HDR;
        r.last    = (pkt_left == 0);
      end else if (phase == PH_PACKET || pkt_left == 0) begin
        phase  = PH_PACKET;
        r.kind = KIND_EXCESS;
      end else begin
        pkt_left = pkt_left - 14'd1;
        if (phase == PH_MSG_HDR) begin
          r.kind    = KIND_MSG_HDR;
          cur_type  = w[31:24];
          r.tval    = code_to_time(w[23:16]);
          msg_left  = size_to_words(w[15:0]);
          addr_idx  = '0;
          mask_half = 0;
          link_left = '0;
          phase     = (msg_left != 0) ? PH_ORIGIN : PH_MSG_HDR;
        end else begin
          if (msg_left != 0) msg_left = msg_left - 14'd1;
          case (phase)
            PH_ORIGIN: begin
              r.kind = KIND_ORIGIN;
              r.part = addr_step(done);
              if (done) phase = PH_TTL;
            end
            PH_TTL: begin
              r.kind    = KIND_TTL_SEQ;
              addr_idx  = '0;
              mask_half = 0;
              case (cur_type)
                MSG_TC:    phase = PH_ANSN;
                MSG_HELLO: phase = PH_HELLO;
                MSG_MID:   phase = PH_MID;
                MSG_HNA:   phase = PH_HNA;
                default:   phase = PH_SKIP;
              endcase
            end
            PH_ANSN: begin
              r.kind = KIND_ANSN;
              phase  = PH_TC_NBR;
            end
            PH_TC_NBR: begin
              r.kind = KIND_TC_NBR;
              r.part = addr_step(done);
            end
            PH_HELLO: begin
              r.kind = KIND_HELLO;
              r.tval = code_to_time(w[15:8]);
              r.will = willingness_of(w[7:0]);
              phase  = PH_LINK_HDR;
            end
            PH_LINK_HDR: begin
              r.kind    = KIND_LINK_HDR;
              r.link    = link_of(w[31:24]);
              link_left = size_to_words(w[15:0]);
              addr_idx  = '0;
              phase     = (link_left != 0) ? PH_LINK_NBR : PH_LINK_HDR;
            end
            PH_LINK_NBR: begin
              r.kind = KIND_LINK_NBR;
              r.part = addr_step(done);
              if (link_left != 0) link_left = link_left - 14'd1;
              if (link_left == 0) begin
                addr_idx = '0;
                phase    = PH_LINK_HDR;
              end
            end
            PH_MID: begin
              r.kind = KIND_MID;
              r.part = addr_step(done);
            end
            PH_HNA: begin
              r.kind = mask_half ? KIND_HNA_MASK : KIND_HNA_NET;
              r.part = addr_step(done);
              if (done) mask_half = ~mask_half;
            end
            default: begin
              r.kind = KIND_SKIP;
              phase  = PH_SKIP;
            end
          endcase
          // message ran out, even inside an address or a link block
          if (msg_left == 0) begin
            phase     = PH_MSG_HDR;
            addr_idx  = '0;
            mask_half = 0;
            link_left = '0;
          end
        end
        // packet ran out, any message still open is dropped
        if (pkt_left == 0) begin
          phase     = PH_PACKET;
          msg_left  = '0;
          link_left = '0;
          addr_idx  = '0;
          mask_half = 0;
          r.last    = 1;
        end
      end
      if (r.kind == KIND_PKT_HDR || r.kind == KIND_EXCESS) begin
        r.mtype  = '0;
        r.tclass = TCLASS_INVALID;
      end else begin
        r.mtype  = cur_type;
        r.tclass = class_of(cur_type);
      end
      owed.push_back(r);
    endfunction

    // result beat: compare with the oldest owed word
    function void check_result(word_result_t got);
      word_result_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d word %h", got.kind, got.echo);
        return;
      end
      want = owed.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch on word %h (expected/actual): kind %0d/%0d type %0d/%0d ",
                    "class %0d/%0d time %0d/%0d will %0d/%0d link %0d/%0d ",
                    "part %0d/%0d echo %h/%h last %0d/%0d"},
                   want.echo, want.kind, got.kind, want.mtype, got.mtype,
                   want.tclass, got.tclass, want.tval, got.tval, want.will, got.will,
                   want.link, got.link, want.part, got.part, want.echo, got.echo,
                   want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  olsr_word_if   word_ch ();
  olsr_result_if result_ch ();

  olsr_packet_word_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .words     (word_ch),
    .results   (result_ch)
  );

  always #4 clk = ~clk;

  word_scoreboard sb = new();

  beat_t       stim[$];
  logic [31:0] msg_words[$];
  logic [31:0] pkt_words[$];

  bit steady;        // no idling on either side while set
  bit hold_req;      // asks the receiver for one long hold-off
  int beats_sent;
  int packets_built;
  int holds_done;
  int mode_writes;

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] pick_will_code();
    case ($urandom_range(0, 6))
      0: return WCODE_NEVER;
      1: return WCODE_LOW;
      2: return WCODE_DEFAULT;
      3: return WCODE_HIGH;
      4: return WCODE_ALWAYS;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_link_code();
    case ($urandom_range(0, 7))
      0: return LCODE_UNSPEC;
      1: return LCODE_ASYM;
      2: return LCODE_SYM;
      3: return LCODE_LOST;
      4: return LCODE_MPR;
      5: return LCODE_PENDING;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_addrs(int n, bit v6);
    for (int i = 0; i < n * (v6 ? 4 : 1); i++) msg_words.push_back($urandom);
  endfunction

  // one message with random content; sloppy ones get wrong size fields
  function automatic void add_message(bit v6, bit sloppy);
    int          aw;
    int          nn;
    logic [7:0]  mtype;
    logic [15:0] sz;
    aw = v6 ? 4 : 1;
    msg_words.delete();
    case ($urandom_range(0, 9))
      0, 1, 2: mtype = MSG_HELLO;
      3, 4:    mtype = MSG_TC;
      5:       mtype = MSG_MID;
      6, 7:    mtype = MSG_HNA;
      default: mtype = 8'($urandom);
    endcase
    add_addrs(1, v6);
    msg_words.push_back($urandom);
    case (mtype)
      MSG_HELLO: begin
        msg_words.push_back({16'($urandom), 8'($urandom), pick_will_code()});
        for (int l = $urandom_range(0, 2); l > 0; l--) begin
          nn = $urandom_range(0, 2);
          sz = 16'(4 * (1 + nn * aw));
          if (sloppy && $urandom_range(0, 3) == 0) sz = 16'($urandom_range(0, 40));
          msg_words.push_back({pick_link_code(), 8'($urandom), sz});
          add_addrs(nn, v6);
        end
      end
      MSG_TC: begin
        msg_words.push_back($urandom);
        add_addrs($urandom_range(0, 3), v6);
      end
      MSG_MID: add_addrs($urandom_range(1, 3), v6);
      MSG_HNA: add_addrs(2 * $urandom_range(1, 2), v6);
      default: for (int k = $urandom_range(0, 3); k > 0; k--) msg_words.push_back($urandom);
    endcase
    sz = 16'(4 * (msg_words.size() + 1));
    if (sloppy) begin
      sz[1:0] = 2'($urandom);
      if ($urandom_range(0, 3) == 0) sz = 16'($urandom_range(0, 48));
    end
    pkt_words.push_back({mtype, 8'($urandom), sz});
    foreach (msg_words[i]) pkt_words.push_back(msg_words[i]);
  endfunction

  // a packet of one to three messages, now and then broken or cut short
  function automatic void add_packet(bit v6);
    bit          sloppy;
    int          cut;
    logic [15:0] plen;
    sloppy = ($urandom_range(0, 3) == 0);
    pkt_words.delete();
    for (int m = $urandom_range(1, 3); m > 0; m--) add_message(v6, sloppy);
    plen = 16'(4 * (pkt_words.size() + 1));
    if (sloppy && $urandom_range(0, 2) == 0) plen = 16'($urandom_range(0, plen + 12));
    stim.push_back('{{plen, 16'($urandom)}, 1'b1});
    cut = pkt_words.size();
    if (sloppy && $urandom_range(0, 3) == 0) cut = $urandom_range(0, pkt_words.size());
    for (int k = 0; k < cut; k++) stim.push_back('{pkt_words[k], 1'b0});
    // stray noise between packets
    if ($urandom_range(0, 9) == 0) stim.push_back('{$urandom, 1'($urandom)});
    packets_built++;
  endfunction

  // offer one beat, changed at the falling edge, taken at a rising edge
  task automatic push_word(input logic [31:0] w, input logic f);
    int gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      word_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    word_ch.valid       = 1;
    word_ch.packet_word = w;
    word_ch.first_word  = f;
    do @(posedge clk); while (!word_ch.ready);
    sb.note_word(w, f);
    beats_sent++;
  endtask

  task automatic send_stim();
    beat_t b;
    while (stim.size() != 0) begin
      b = stim.pop_front();
      push_word(b.w, b.f);
    end
    @(negedge clk);
    word_ch.valid = 0;
  endtask

  // mode register, written only once every owed word has come back
  task automatic write_mode(input logic m);
    while (sb.owed.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we    = 0;
    sb.ipv6   = m;
    mode_writes++;
  endtask

  task automatic put(input logic [31:0] w, input logic f);
    stim.push_back('{w, f});
  endtask

  // receiver: random stalls, plus the long hold-off on request
  initial begin
    int idle_left;
    idle_left       = 0;
    result_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req        = 0;
        holds_done++;
        result_ch.ready = 0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_left > 0) begin
        result_ch.ready = 0;
        idle_left--;
      end else begin
        result_ch.ready = 1;
        if (!steady && $urandom_range(0, 3) == 0) idle_left = pick_gap();
      end
    end
  end

  // result beats are taken at the rising edge
  always @(posedge clk) begin : take_result
    word_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.kind   = kind_t'(result_ch.word_kind);
      got.mtype  = result_ch.msg_type;
      got.tclass = type_class_t'(result_ch.type_class);
      got.tval   = result_ch.time_value;
      got.will   = will_class_t'(result_ch.willingness_class);
      got.link   = link_class_t'(result_ch.link_class);
      got.part   = result_ch.address_part;
      got.echo   = result_ch.word_echo;
      got.last   = result_ch.last_of_packet;
      sb.check_result(got);
    end
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("[olsr_packet_word_parser_unit] ERROR");
    $finish;
  end

  initial begin
    rst                 = 1;
    cfg_we              = 0;
    cfg_wdata           = 0;
    word_ch.valid       = 0;
    word_ch.packet_word = '0;
    word_ch.first_word  = 0;
    steady              = 0;
    hold_req            = 0;
    beats_sent          = 0;
    packets_built       = 0;
    holds_done          = 0;
    mode_writes         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed, ipv4: empty and short headers, an oversize header cut off
    // by a new one, then one packet with every message kind
    write_mode(0);
    put(32'h0000_ABCD, 1);
    put(32'h0003_0001, 1);
    put(32'hFFFF_FFFF, 1);
    put({16'd100, 16'h0001}, 1);
    // hello, longest validity time, empty mpr link block, one sym neighbor
    put({MSG_HELLO, 8'hFF, 16'd28}, 0);
    put(32'h0A00_0001, 0);
    put(32'hFF00_0000, 0);
    put({16'h0000, 8'h00, WCODE_ALWAYS}, 0);
    put({LCODE_MPR, 8'h00, 16'd4}, 0);
    put({LCODE_SYM, 8'h00, 16'd8}, 0);
    put(32'hC0A8_0001, 0);
    // message with no following words
    put({MSG_TC, 8'h00, 16'd0}, 0);
    put({MSG_TC, 8'h11, 16'd20}, 0);
    put(32'h0A00_0002, 0);
    put(32'h01FF_FFFF, 0);
    put({16'hFFFF, 16'h0000}, 0);
    put(32'hC0A8_0002, 0);
    put({MSG_HNA, 8'h22, 16'd20}, 0);
    put(32'h0A00_0003, 0);
    put(32'h0200_0002, 0);
    put(32'hC0A8_0000, 0);
    put(32'hFFFF_FF00, 0);
    // unknown type, body skipped
    put({8'h00, 8'h0F, 16'd16}, 0);
    put(32'h0A00_0004, 0);
    put(32'h0300_0003, 0);
    put(32'h5555_AAAA, 0);
    // packet ends inside this message, the next word is excess
    put({MSG_MID, 8'h30, 16'd40}, 0);
    put(32'h0A00_0005, 0);
    put(32'h0000_0000, 0);
    send_stim();

    // ipv6 address cut short by a switch back to ipv4
    write_mode(1);
    put({16'd60, 16'h0002}, 1);
    put({MSG_MID, 8'h00, 16'd56}, 0);
    put(32'h2001_0DB8, 0);
    put(32'h0000_0000, 0);
    send_stim();
    write_mode(0);
    put(32'h0000_0001, 0);
    put(32'h0400_0004, 0);
    put(32'h0A00_0006, 0);
    send_stim();

    // random phases in alternating modes, one of them without idling,
    // each opening with a long receiver hold-off while words keep coming
    for (int p = 0; p < PHASES; p++) begin
      write_mode(p % 2 == 0);
      steady = (p == 2);
      while (stim.size() < PHASE_WORDS) add_packet(sb.ipv6);
      hold_req = 1;
      send_stim();
    end
    steady = 0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input words in %0d random packets, %0d result beats checked",
             beats_sent, packets_built, sb.checked);
    $display("both address modes over %0d mode writes, %0d long receiver hold-offs",
             mode_writes, holds_done);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("[olsr_packet_word_parser_unit] OK");
    end else begin
      $display("%0d mismatches, %0d words never answered", sb.mismatches, sb.owed.size());
      $display("[olsr_packet_word_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
